### sv/dac_setpoint_trim_controller_assert.svh
// Assertion macros for the DAC setpoint trim controller.
// Used by dac_setpoint_trim_controller; expects clk and rst in scope.
`ifndef DAC_SETPOINT_TRIM_CONTROLLER_ASSERT_SVH
`define DAC_SETPOINT_TRIM_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSTC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSTC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### sv/dstc_pkg.sv
// Package for the DAC setpoint trim controller: payload structs, codes, fixed constants.
// No dependencies.
package dstc_pkg;

  localparam int CODE_BITS = 12;

  localparam logic [1:0] KIND_SETPOINT = 2'd0;
  localparam logic [1:0] KIND_MEASURE  = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;
  localparam logic [1:0] KIND_ABORT    = 2'd3;

  localparam logic [2:0] STATUS_SETTLED  = 3'd0;
  localparam logic [2:0] STATUS_RAMPING  = 3'd1;
  localparam logic [2:0] STATUS_AWAIT    = 3'd2;
  localparam logic [2:0] STATUS_ABORTED  = 3'd3;
  localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;
  localparam logic [2:0] STATUS_AT_LIMIT = 3'd5;

  localparam logic [1:0] CFG_SENSE_RATIO     = 2'd0;
  localparam logic [1:0] CFG_VREF_MV         = 2'd1;
  localparam logic [1:0] CFG_MAX_CORRECTIONS = 2'd2;

  localparam logic [15:0] SENSE_RATIO_RESET     = 16'd2560;
  localparam logic [14:0] VREF_MV_RESET         = 15'd10000;
  localparam logic [3:0]  MAX_CORRECTIONS_RESET = 4'd9;

  // 120.0 percent in Q16.16
  localparam logic [31:0] DRIVE_LIMIT = 32'(120) << 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target_pct;
    logic        accurate;
    logic [15:0] measured_pct;
  } item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] dac_code;
    logic [2:0]           status;
    logic [3:0]           corrections_done;
  } result_t;

endpackage

### sv/dac_setpoint_trim_controller.sv
// DAC setpoint trim controller: sequencer around one shared restoring divider.
// Depends on dstc_pkg and dac_setpoint_trim_controller_assert.svh.
//
// Usage:
//   item channel (item_valid/item_ready, item) carries one command per transaction:
//   setpoint, measurement, millisecond tick or abort. Every item yields exactly one
//   result on the result channel (result_valid/result_ready, result).
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sense_ratio,
//   vref_mv and max_corrections; write only while no item is in flight.
// Sequence from accept to result_valid:
//   tick, abort, ignored measurement: S_OUT; in-band measurement: S_MEAS, S_OUT.
//   setpoint: divisions for drive level, then DAC code, on the shared divider;
//   only the DAC code division when sense_ratio is 0.
//   correcting measurement: S_MEAS and both divisions; a zero measurement skips
//   the drive division. The 48-bit divider gives one quotient bit a cycle; a new
//   item is taken only once the sequencer is back in idle.
// item_ready is high only while the sequencer is idle. A finished result sits in
// the output register; the next item is accepted while it waits, and that item's
// result is held back until the receiver takes the earlier one.
// Reset (rst, synchronous) restores register defaults, DAC code 0, phase idle.
module dac_setpoint_trim_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  dstc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output dstc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  `include "dac_setpoint_trim_controller_assert.svh"

  localparam int CB      = dstc_pkg::CODE_BITS;
  localparam int DIV_W   = 48;
  localparam int DEN_W   = 24;
  localparam int CNT_W   = $clog2(DIV_W);

  typedef enum logic [2:0] {
    S_IDLE, S_MEAS, S_CODE, S_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RAMP, PH_AWAIT, PH_ABORT, PH_TIMEOUT, PH_SETTLED
  } phase_t;

  typedef enum logic {
    OP_DRIVE, OP_CODE
  } div_op_t;

  state_t  state;
  phase_t  phase;
  div_op_t div_op;

  logic [15:0]    sense_ratio;
  logic [14:0]    vref_mv;
  logic [3:0]     max_corrections;

  logic [CB-1:0]  dac_now;
  logic [CB-1:0]  goal_code;
  logic [31:0]    drive_level;
  logic [15:0]    set_target;
  logic [3:0]     tries;
  logic           mode_accurate;
  logic [1:0]     kind_q;
  logic [15:0]    meas_q;

  logic [DIV_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;
  logic [DEN_W-1:0] div_den;
  logic [CNT_W-1:0] div_cnt;

  // shared divider step
  logic [DEN_W:0]   rem_sh;
  logic             quo_bit;
  logic [DEN_W-1:0] rem_next;
  logic [DIV_W-1:0] quo_next;

  assign rem_sh   = {div_rem, div_quo[DIV_W-1]};
  assign quo_bit  = (rem_sh >= {1'b0, div_den});
  assign rem_next = quo_bit ? DEN_W'(rem_sh - {1'b0, div_den}) : DEN_W'(rem_sh);
  assign quo_next = {div_quo[DIV_W-2:0], quo_bit};

  // operand preparation
  logic [19:0]      tgt10;
  logic [DIV_W-1:0] sp_num;
  logic [DEN_W-1:0] sp_den;
  logic [31:0]      drive_min;
  logic [28:0]      code_prod;
  logic [DIV_W-1:0] code_num;
  logic [14:0]      vref_eff;
  logic [DIV_W-1:0] corr_num;
  logic [22:0]      m100;
  logic [22:0]      t98;
  logic [22:0]      t102;
  logic             in_band;
  logic [31:0]      drive_sat;
  logic [3:0]       tries_inc;
  logic [3:0]       corr_limit;

  assign tgt10     = 20'(item.target_pct) * 20'(10);
  assign sp_num    = DIV_W'({tgt10, 24'd0});
  assign sp_den    = DEN_W'(sense_ratio) * DEN_W'(100);
  assign drive_min = (drive_level > dstc_pkg::DRIVE_LIMIT) ? dstc_pkg::DRIVE_LIMIT
                                                           : drive_level;
  assign code_prod = 29'(drive_min) * 29'(50);
  assign code_num  = DIV_W'({code_prod, {CB{1'b0}}} >> 16);
  assign vref_eff  = (vref_mv == '0) ? 15'd1 : vref_mv;
  assign corr_num  = DIV_W'(drive_level) * DIV_W'(set_target);
  assign m100      = 23'(meas_q) * 23'(100);
  assign t98       = 23'(set_target) * 23'(98);
  assign t102      = 23'(set_target) * 23'(102);
  assign in_band   = (m100 >= t98) && (m100 <= t102);
  assign drive_sat = (|quo_next[DIV_W-1:32]) ? 32'hFFFF_FFFF : quo_next[31:0];
  assign tries_inc = (tries == 4'd15) ? 4'd15 : tries + 4'd1;
  assign corr_limit = (max_corrections == '0) ? 4'd1 : max_corrections;

  // phase after ramp arrival check, and the status it reports
  phase_t     phase_fin;
  logic [2:0] status_fin;

  always_comb begin
    phase_fin = phase;
    if (phase == PH_RAMP && dac_now == goal_code) begin
      phase_fin = (mode_accurate && set_target != '0) ? PH_AWAIT : PH_SETTLED;
    end
    unique case (phase_fin)
      PH_RAMP:    status_fin = dstc_pkg::STATUS_RAMPING;
      PH_AWAIT:   status_fin = dstc_pkg::STATUS_AWAIT;
      PH_ABORT:   status_fin = dstc_pkg::STATUS_ABORTED;
      PH_TIMEOUT: status_fin = dstc_pkg::STATUS_TIMEOUT;
      PH_SETTLED: status_fin = (drive_level > dstc_pkg::DRIVE_LIMIT) ?
                               dstc_pkg::STATUS_AT_LIMIT : dstc_pkg::STATUS_SETTLED;
      default:    status_fin = dstc_pkg::STATUS_SETTLED;
    endcase
  end

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_IDLE;
      div_op          <= OP_DRIVE;
      result_valid    <= 1'b0;
      sense_ratio     <= dstc_pkg::SENSE_RATIO_RESET;
      vref_mv         <= dstc_pkg::VREF_MV_RESET;
      max_corrections <= dstc_pkg::MAX_CORRECTIONS_RESET;
      dac_now         <= '0;
      goal_code       <= '0;
      drive_level     <= '0;
      set_target      <= '0;
      tries           <= '0;
      mode_accurate   <= 1'b0;
      kind_q          <= dstc_pkg::KIND_SETPOINT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dstc_pkg::CFG_SENSE_RATIO:     sense_ratio     <= cfg_data;
          dstc_pkg::CFG_VREF_MV:         vref_mv         <= cfg_data[14:0];
          dstc_pkg::CFG_MAX_CORRECTIONS: max_corrections <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            kind_q <= item.kind;
            meas_q <= item.measured_pct;
            unique case (item.kind)
              dstc_pkg::KIND_SETPOINT: begin
                set_target    <= item.target_pct;
                mode_accurate <= item.accurate;
                tries         <= '0;
                if (sense_ratio == '0) begin
                  drive_level <= 32'hFFFF_FFFF;
                  state       <= S_CODE;
                end else begin
                  div_quo <= sp_num;
                  div_den <= sp_den;
                  div_rem <= '0;
                  div_cnt <= '0;
                  div_op  <= OP_DRIVE;
                  state   <= S_DIV;
                end
              end
              dstc_pkg::KIND_MEASURE: begin
                state <= (phase == PH_AWAIT) ? S_MEAS : S_OUT;
              end
              dstc_pkg::KIND_TICK: begin
                if (dac_now < goal_code) begin
                  dac_now <= dac_now + CB'(1);
                end else if (dac_now > goal_code) begin
                  dac_now <= dac_now - CB'(1);
                end
                state <= S_OUT;
              end
              default: begin
                goal_code   <= '0;
                drive_level <= '0;
                phase       <= PH_ABORT;
                state       <= S_OUT;
              end
            endcase
          end
        end

        S_MEAS: begin
          if (in_band) begin
            phase <= PH_SETTLED;
            state <= S_OUT;
          end else if (meas_q == '0) begin
            drive_level <= 32'hFFFF_FFFF;
            state       <= S_CODE;
          end else begin
            div_quo <= corr_num;
            div_den <= DEN_W'(meas_q);
            div_rem <= '0;
            div_cnt <= '0;
            div_op  <= OP_DRIVE;
            state   <= S_DIV;
          end
        end

        S_CODE: begin
          div_quo <= code_num;
          div_den <= DEN_W'(vref_eff);
          div_rem <= '0;
          div_cnt <= '0;
          div_op  <= OP_CODE;
          state   <= S_DIV;
        end

        S_DIV: begin
          div_quo <= quo_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DIV_W - 1)) begin
            if (div_op == OP_DRIVE) begin
              drive_level <= drive_sat;
              state       <= S_CODE;
            end else begin
              goal_code <= quo_next[CB-1:0];
              if (kind_q == dstc_pkg::KIND_SETPOINT) begin
                phase <= PH_RAMP;
              end else begin
                tries <= tries_inc;
                phase <= (tries_inc >= corr_limit) ? PH_TIMEOUT : PH_RAMP;
              end
              state <= S_OUT;
            end
          end
        end

        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid            <= 1'b1;
            result.dac_code         <= dac_now;
            result.status           <= status_fin;
            result.corrections_done <= tries;
            phase                   <= phase_fin;
            state                   <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `DSTC_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
    "item accepted but block still ready next cycle")
  `DSTC_ASSERT_NOW(a_div_den_nonzero, state == S_DIV, div_den != '0,
    "shared divider running with zero divisor")
  `DSTC_ASSERT_NOW(a_status_code, result_valid, result.status <= dstc_pkg::STATUS_AT_LIMIT,
    "result carries an undefined status code")

endmodule

### tb/tb.sv
// Testbench for dac_setpoint_trim_controller: directed and random command streams
// checked against an in-bench model of the ramp and trim loop.
// Depends on dstc_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb;

  typedef enum logic [2:0] {
    LOOP_IDLE, LOOP_RAMP, LOOP_AWAIT, LOOP_ABORT, LOOP_TIMEOUT, LOOP_SETTLED
  } loop_phase_t;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARE} ready_pattern_t;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  dstc_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  dstc_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;

  dac_setpoint_trim_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // loop model state
  logic [15:0]                    ratio_q;
  logic [14:0]                    vref_q;
  logic [3:0]                     corr_limit_q;
  logic [dstc_pkg::CODE_BITS-1:0] dac_now_q;
  logic [dstc_pkg::CODE_BITS-1:0] goal_q;
  logic [31:0]                    drive_q;
  logic [15:0]                    target_q;
  logic [3:0]                     tries_q;
  loop_phase_t                    phase_q;
  logic                           accurate_q;

  dstc_pkg::result_t expected_dac_reports[$];
  dstc_pkg::result_t report_want;
  int                fail_count;
  int                burst_left;
  int                gap_len;
  int                holdoff_request;
  int                holdoff_left;
  int                pattern_left;
  ready_pattern_t    pattern_mode;

  function automatic logic [dstc_pkg::CODE_BITS-1:0] code_for_drive(logic [31:0] drive);
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] q;
    d = (drive > dstc_pkg::DRIVE_LIMIT) ? 64'(dstc_pkg::DRIVE_LIMIT) : 64'(drive);
    v = (vref_q == '0) ? 64'd1 : 64'(vref_q);
    q = (d * 64'd50 * (64'd1 << dstc_pkg::CODE_BITS)) / (v * 64'd65536);
    return q[dstc_pkg::CODE_BITS-1:0];
  endfunction

  function automatic logic [31:0] drive_for_target(logic [15:0] t);
    logic [63:0] nd;
    if (ratio_q == '0) begin
      nd = 64'hFFFF_FFFF;
    end else begin
      nd = (64'(t) * 64'd2560 * 64'd65536) / (64'(ratio_q) * 64'd100);
      if (nd > 64'hFFFF_FFFF) nd = 64'hFFFF_FFFF;
    end
    return nd[31:0];
  endfunction

  function automatic void advance_on_arrival();
    if (phase_q == LOOP_RAMP && dac_now_q == goal_q)
      phase_q = (accurate_q && target_q != '0) ? LOOP_AWAIT : LOOP_SETTLED;
  endfunction

  function automatic void trim_with_measurement(logic [15:0] meas);
    logic [63:0] t;
    logic [63:0] m100;
    logic [63:0] nd;
    logic [3:0]  lim;
    t = 64'(target_q);
    m100 = 64'(meas) * 64'd100;
    if (m100 >= 64'd98 * t && m100 <= 64'd102 * t) begin
      phase_q = LOOP_SETTLED;
    end else begin
      if (meas == '0) begin
        nd = 64'hFFFF_FFFF;
      end else begin
        nd = (64'(drive_q) * t) / 64'(meas);
        if (nd > 64'hFFFF_FFFF) nd = 64'hFFFF_FFFF;
      end
      drive_q = nd[31:0];
      goal_q = code_for_drive(drive_q);
      if (tries_q < 4'd15) tries_q++;
      lim = (corr_limit_q == '0) ? 4'd1 : corr_limit_q;
      if (tries_q >= lim) begin
        phase_q = LOOP_TIMEOUT;
      end else begin
        phase_q = LOOP_RAMP;
        advance_on_arrival();
      end
    end
  endfunction

  function automatic dstc_pkg::result_t predict_dac_report(dstc_pkg::item_t it);
    dstc_pkg::result_t r;
    case (it.kind)
      dstc_pkg::KIND_SETPOINT: begin
        target_q = it.target_pct;
        accurate_q = it.accurate;
        tries_q = '0;
        drive_q = drive_for_target(target_q);
        goal_q = code_for_drive(drive_q);
        phase_q = LOOP_RAMP;
        advance_on_arrival();
      end
      dstc_pkg::KIND_MEASURE: begin
        if (phase_q == LOOP_AWAIT) trim_with_measurement(it.measured_pct);
      end
      dstc_pkg::KIND_TICK: begin
        if (dac_now_q < goal_q) dac_now_q++;
        else if (dac_now_q > goal_q) dac_now_q--;
        advance_on_arrival();
      end
      dstc_pkg::KIND_ABORT: begin
        goal_q = '0;
        drive_q = '0;
        phase_q = LOOP_ABORT;
      end
    endcase
    case (phase_q)
      LOOP_RAMP:    r.status = dstc_pkg::STATUS_RAMPING;
      LOOP_AWAIT:   r.status = dstc_pkg::STATUS_AWAIT;
      LOOP_ABORT:   r.status = dstc_pkg::STATUS_ABORTED;
      LOOP_TIMEOUT: r.status = dstc_pkg::STATUS_TIMEOUT;
      LOOP_SETTLED: r.status = (drive_q > dstc_pkg::DRIVE_LIMIT) ?
                               dstc_pkg::STATUS_AT_LIMIT : dstc_pkg::STATUS_SETTLED;
      default:      r.status = dstc_pkg::STATUS_SETTLED;
    endcase
    r.dac_code = dac_now_q;
    r.corrections_done = tries_q;
    return r;
  endfunction

  function automatic dstc_pkg::item_t make_item(logic [1:0] kind, logic [15:0] target,
                                                logic acc, logic [15:0] meas);
    dstc_pkg::item_t it;
    it.kind = kind;
    it.target_pct = target;
    it.accurate = acc;
    it.measured_pct = meas;
    return it;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %0t: %s expected %0d got %0d", $time, what, want, got);
  endfunction

  task automatic send_item(input dstc_pkg::item_t it);
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_dac_reports.push_back(predict_dac_report(it));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_len > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_dac_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      dstc_pkg::CFG_SENSE_RATIO:     ratio_q = data;
      dstc_pkg::CFG_VREF_MV:         vref_q = data[14:0];
      dstc_pkg::CFG_MAX_CORRECTIONS: corr_limit_q = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] ratio, input logic [15:0] vref,
                                input logic [15:0] limit);
    drain_results();
    cfg_write(dstc_pkg::CFG_SENSE_RATIO, ratio);
    cfg_write(dstc_pkg::CFG_VREF_MV, vref);
    cfg_write(dstc_pkg::CFG_MAX_CORRECTIONS, limit);
  endtask

  // prefer targets whose goal lies near the present code to keep ramps short
  function automatic logic [15:0] pick_target();
    logic [15:0]                    t;
    logic [dstc_pkg::CODE_BITS-1:0] g;
    int                             code_gap;
    for (int k = 0; k < 8; k++) begin
      t = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 400)) : 16'($urandom());
      g = code_for_drive(drive_for_target(t));
      code_gap = (g > dac_now_q) ? int'(g - dac_now_q) : int'(dac_now_q - g);
      if (code_gap <= 40) return t;
    end
    return t;
  endfunction

  function automatic dstc_pkg::item_t random_item();
    dstc_pkg::item_t it;
    int              r;
    int              code_gap;
    int              m;
    r = $urandom_range(0, 99);
    code_gap = (goal_q > dac_now_q) ? int'(goal_q - dac_now_q) : int'(dac_now_q - goal_q);
    it = make_item(dstc_pkg::KIND_TICK, 16'($urandom()), 1'($urandom()), 16'($urandom()));
    if (r < 8) begin
      it.kind = 2'($urandom());
    end else begin
      case (phase_q)
        LOOP_RAMP: begin
          if (code_gap > 60 && r < 50) it.kind = dstc_pkg::KIND_SETPOINT;
          else if (code_gap > 60 && r < 70) it.kind = dstc_pkg::KIND_ABORT;
          else if (r > 97) it.kind = dstc_pkg::KIND_ABORT;
        end
        LOOP_AWAIT: begin
          it.kind = dstc_pkg::KIND_MEASURE;
          if (r < 40) m = (int'(target_q) * $urandom_range(97, 103) + 50) / 100;
          else if (r < 90) m = (int'(target_q) * $urandom_range(40, 170)) / 100;
          else if (r < 95) m = 0;
          else m = $urandom_range(0, 65535);
          it.measured_pct = (m > 65535) ? 16'hFFFF : 16'(m);
        end
        LOOP_ABORT: begin
          if (dac_now_q > 60 || r > 70) it.kind = dstc_pkg::KIND_SETPOINT;
        end
        default: begin
          if (r < 75) it.kind = dstc_pkg::KIND_SETPOINT;
          else if (r < 88) it.kind = dstc_pkg::KIND_MEASURE;
          else if (r > 95) it.kind = dstc_pkg::KIND_ABORT;
        end
      endcase
      if (it.kind == dstc_pkg::KIND_SETPOINT) begin
        it.target_pct = pick_target();
        it.accurate = ($urandom_range(0, 4) != 0);
      end
    end
    return it;
  endfunction

  task automatic run_random_items(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  task automatic test_directed_sequence();
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd0, 1'b1, 16'd0));
    send_item(make_item(dstc_pkg::KIND_MEASURE, 16'd0, 1'b0, 16'hFFFF));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd25, 1'b1, 16'd0));
    repeat (5) send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_MEASURE, 16'd0, 1'b0, 16'd25));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd25, 1'b1, 16'd0));
    send_item(make_item(dstc_pkg::KIND_MEASURE, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_TICK, 16'hFFFF, 1'b1, 16'hFFFF));
    send_item(make_item(dstc_pkg::KIND_ABORT, 16'd0, 1'b0, 16'd0));
    repeat (2) send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'hFFFF, 1'b0, 16'hFFFF));
    send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_ABORT, 16'hFFFF, 1'b1, 16'hFFFF));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd0, 1'b0, 16'd0));
    repeat (6) send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
  endtask

  task automatic test_config_corners();
    apply_settings(16'd0, 16'd0, 16'd0);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd5000, 1'b1, 16'd0));
    repeat (4) send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_MEASURE, 16'd0, 1'b0, 16'd1000));
    send_item(make_item(dstc_pkg::KIND_MEASURE, 16'd0, 1'b0, 16'd1000));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd5000, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'hFFFF, 1'b1, 16'd0));
    send_item(make_item(dstc_pkg::KIND_ABORT, 16'd0, 1'b0, 16'd0));
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd0, 1'b1, 16'd0));
  endtask

  task automatic test_backpressure();
    apply_settings(dstc_pkg::SENSE_RATIO_RESET, 16'(dstc_pkg::VREF_MV_RESET),
                   16'(dstc_pkg::MAX_CORRECTIONS_RESET));
    holdoff_request = 400;
    burst_left = 40;
    send_item(make_item(dstc_pkg::KIND_SETPOINT, 16'd60, 1'b0, 16'd0));
    repeat (14) send_item(make_item(dstc_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0));
    drain_results();
  endtask

  task automatic test_random_settings();
    apply_settings(dstc_pkg::SENSE_RATIO_RESET, 16'(dstc_pkg::VREF_MV_RESET),
                   16'(dstc_pkg::MAX_CORRECTIONS_RESET));
    run_random_items(350);
    apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 20000)),
                   16'($urandom_range(1, 15)));
    run_random_items(350);
    apply_settings(16'd1, 16'd20000, 16'd15);
    run_random_items(250);
    apply_settings(16'd65535, 16'd1, 16'd1);
    run_random_items(150);
    apply_settings(16'($urandom_range(256, 8000)), 16'($urandom_range(1000, 20000)),
                   16'($urandom_range(1, 15)));
    run_random_items(350);
    apply_settings(dstc_pkg::SENSE_RATIO_RESET, 16'd20000, 16'd3);
    run_random_items(300);
  endtask

  always @(negedge clk) begin
    if (holdoff_request > 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = ready_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(10, 200);
      end
      pattern_left--;
      case (pattern_mode)
        READY_ALWAYS: result_ready <= 1'b1;
        READY_HALF:   result_ready <= ($urandom_range(0, 1) == 1);
        READY_MOSTLY: result_ready <= ($urandom_range(0, 6) != 0);
        default:      result_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_dac_reports.size() == 0) begin
        note_mismatch("unexpected transaction, dac_code", -1, int'(result.dac_code));
      end else begin
        report_want = expected_dac_reports.pop_front();
        if (result.dac_code !== report_want.dac_code)
          note_mismatch("dac_code", int'(report_want.dac_code), int'(result.dac_code));
        if (result.status !== report_want.status)
          note_mismatch("status", int'(report_want.status), int'(result.status));
        if (result.corrections_done !== report_want.corrections_done)
          note_mismatch("corrections_done", int'(report_want.corrections_done),
                        int'(result.corrections_done));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dstc_pkg::CFG_SENSE_RATIO;
    cfg_data = '0;
    fail_count = 0;
    burst_left = 0;
    gap_len = 0;
    holdoff_request = 0;
    holdoff_left = 0;
    pattern_left = 0;
    pattern_mode = READY_ALWAYS;
    ratio_q = dstc_pkg::SENSE_RATIO_RESET;
    vref_q = dstc_pkg::VREF_MV_RESET;
    corr_limit_q = dstc_pkg::MAX_CORRECTIONS_RESET;
    dac_now_q = '0;
    goal_q = '0;
    drive_q = '0;
    target_q = '0;
    tries_q = '0;
    phase_q = LOOP_IDLE;
    accurate_q = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_config_corners();
    test_backpressure();
    test_random_settings();
    drain_results();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### dac_setpoint_trim_controller.f
+incdir+sv
sv/dstc_pkg.sv
sv/dac_setpoint_trim_controller.sv
tb/tb.sv
